@@ hdl/corridor_obstacle_speed_limiter_unit_defines.svh @@
// Assertion macros shared by the limiter RTL.
// Included by every module that carries concurrent checks; needs aclk and aresetn in scope.
`ifndef CORRIDOR_OBSTACLE_SPEED_LIMITER_UNIT_DEFINES_SVH
`define CORRIDOR_OBSTACLE_SPEED_LIMITER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset
`define COSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every edge, reset included
`define COSL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define COSL_ASSERT(label, prop, msg)
`define COSL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ hdl/cosl_pkg.sv @@
// Shared types, codes and constants of the corridor obstacle speed limiter.
// No dependencies; used by cosl_ctrl, cosl_dp and the top level.
`default_nettype none
package cosl_pkg;

    typedef enum logic [2:0] {
        OP_POINT    = 3'd0,
        OP_END_SCAN = 3'd1,
        OP_VELOCITY = 3'd2,
        OP_DISABLE  = 3'd3,
        OP_ENABLE   = 3'd4,
        OP_TICK     = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        DEC_DISABLED = 3'd0,
        DEC_NON_FWD  = 3'd1,
        DEC_STALE    = 3'd2,
        DEC_REVERSE  = 3'd3,
        DEC_STOP     = 3'd4,
        DEC_LIMITED  = 3'd5,
        DEC_FREE     = 3'd6
    } dec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic mul_en;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_velocity;
        logic ramp_needed;
        logic div_last;
        logic out_full;
    } sts_t;

    localparam logic [2:0] REG_LATERAL_TOL  = 3'd0;
    localparam logic [2:0] REG_ALLOW_REV    = 3'd1;
    localparam logic [2:0] REG_REV_FLOOR    = 3'd2;
    localparam logic [2:0] REG_STOP_DIST    = 3'd3;
    localparam logic [2:0] REG_SLOW_START   = 3'd4;
    localparam logic [2:0] REG_FWD_MAX      = 3'd5;
    localparam logic [2:0] REG_REV_MAX      = 3'd6;
    localparam logic [2:0] REG_TIMEOUT      = 3'd7;

    localparam logic [14:0] FAR_DIST = 15'h7fff;
    localparam logic [15:0] AGE_MAX  = 16'hffff;
    localparam logic [7:0]  MIN_RADIUS_SQ = 8'd100;

    localparam logic [14:0]        RST_LATERAL_TOL = 15'd1000;
    localparam logic               RST_ALLOW_REV   = 1'b1;
    localparam logic [14:0]        RST_REV_FLOOR   = 15'd1000;
    localparam logic [14:0]        RST_STOP_DIST   = 15'd1500;
    localparam logic [14:0]        RST_SLOW_START  = 15'd3000;
    localparam logic [14:0]        RST_FWD_MAX     = 15'd1000;
    localparam logic signed [15:0] RST_REV_MAX     = -16'sd1000;
    localparam logic [15:0]        RST_TIMEOUT     = 16'd1000;

    // Restoring divider: 31-bit dividend magnitude, one bit a cycle
    localparam int DIV_STEPS = 31;
    localparam int DIV_CNT_W = 5;

    function automatic logic [7:0] sq_small(input logic [3:0] v);
        logic [7:0] w;
        w = {4'd0, v};
        return w * w;
    endfunction

endpackage
`default_nettype wire

@@ hdl/cosl_ctrl.sv @@
// Controller of the speed limiter: sequences multiply, divide and result load.
// Depends on cosl_pkg and the assertion header.
`default_nettype none
`include "corridor_obstacle_speed_limiter_unit_defines.svh"
module cosl_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire cosl_pkg::sts_t  sts,
    output cosl_pkg::cmd_t       cmd
);

    cosl_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cosl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cosl_pkg::ST_IDLE: begin
                if (cmd.take && sts.op_velocity) begin
                    state_next = sts.ramp_needed ? cosl_pkg::ST_MUL : cosl_pkg::ST_FIN;
                end
            end
            cosl_pkg::ST_MUL:  state_next = cosl_pkg::ST_LOAD;
            cosl_pkg::ST_LOAD: state_next = cosl_pkg::ST_DIV;
            cosl_pkg::ST_DIV: begin
                if (sts.div_last) begin
                    state_next = cosl_pkg::ST_FIN;
                end
            end
            cosl_pkg::ST_FIN:  state_next = cosl_pkg::ST_IDLE;
            default:           state_next = cosl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        // hold a velocity request back while the previous result is untaken
        s_ready      = (state_reg == cosl_pkg::ST_IDLE) && !(sts.op_velocity && sts.out_full);
        cmd.take     = s_valid && s_ready;
        cmd.mul_en   = (state_reg == cosl_pkg::ST_MUL);
        cmd.div_load = (state_reg == cosl_pkg::ST_LOAD);
        cmd.div_step = (state_reg == cosl_pkg::ST_DIV);
        cmd.out_load = (state_reg == cosl_pkg::ST_FIN);
    end

    `COSL_ASSERT(a_ready_only_idle, s_ready |-> state_reg == cosl_pkg::ST_IDLE, "ready outside idle")
    `COSL_ASSERT(a_fin_slot_free, state_reg == cosl_pkg::ST_FIN |-> !sts.out_full, "result slot busy at load")

endmodule
`default_nettype wire

@@ hdl/cosl_dp.sv @@
// Datapath of the speed limiter: registers, scan state, ages, multiplier, divider, output.
// Depends on cosl_pkg and the assertion header; driven by cosl_ctrl.
`default_nettype none
`include "corridor_obstacle_speed_limiter_unit_defines.svh"
module cosl_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic [2:0]         s_opcode,
    input  wire logic signed [15:0] s_point_x,
    input  wire logic signed [15:0] s_point_y,
    input  wire logic signed [15:0] s_speed_request,
    input  wire logic signed [15:0] s_turn_request,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_speed_out,
    output logic signed [15:0]      m_turn_out,
    output logic [2:0]              m_decision,
    input  wire cosl_pkg::cmd_t     cmd,
    output cosl_pkg::sts_t          sts
);

    // configuration
    logic [14:0]        lat_reg, floor_reg, stop_reg, slow_reg, fwd_max_reg;
    logic               allow_rev_reg;
    logic signed [15:0] rev_max_reg;
    logic [15:0]        timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg       <= cosl_pkg::RST_LATERAL_TOL;
            allow_rev_reg <= cosl_pkg::RST_ALLOW_REV;
            floor_reg     <= cosl_pkg::RST_REV_FLOOR;
            stop_reg      <= cosl_pkg::RST_STOP_DIST;
            slow_reg      <= cosl_pkg::RST_SLOW_START;
            fwd_max_reg   <= cosl_pkg::RST_FWD_MAX;
            rev_max_reg   <= cosl_pkg::RST_REV_MAX;
            timeout_reg   <= cosl_pkg::RST_TIMEOUT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cosl_pkg::REG_LATERAL_TOL: lat_reg       <= cfg_wdata[14:0];
                cosl_pkg::REG_ALLOW_REV:   allow_rev_reg <= cfg_wdata[0];
                cosl_pkg::REG_REV_FLOOR:   floor_reg     <= cfg_wdata[14:0];
                cosl_pkg::REG_STOP_DIST:   stop_reg      <= cfg_wdata[14:0];
                cosl_pkg::REG_SLOW_START:  slow_reg      <= cfg_wdata[14:0];
                cosl_pkg::REG_FWD_MAX:     fwd_max_reg   <= cfg_wdata[14:0];
                cosl_pkg::REG_REV_MAX:     rev_max_reg   <= cfg_wdata;
                cosl_pkg::REG_TIMEOUT:     timeout_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- request decode ----------------
    cosl_pkg::op_t op;
    assign op = cosl_pkg::op_t'(s_opcode);

    // point filter: x*x+y*y < 100 only when both coordinates lie in -9..9
    logic       small_x, small_y, near_origin, wide_y, keep_point;
    logic [3:0] ax4, ay4;
    logic [7:0] r2;
    logic [16:0] ay17;

    always_comb begin
        small_x     = (s_point_x >= -16'sd9) && (s_point_x <= 16'sd9);
        small_y     = (s_point_y >= -16'sd9) && (s_point_y <= 16'sd9);
        ax4         = s_point_x[15] ? 4'(16'd0 - s_point_x) : s_point_x[3:0];
        ay4         = s_point_y[15] ? 4'(16'd0 - s_point_y) : s_point_y[3:0];
        r2          = cosl_pkg::sq_small(ax4) + cosl_pkg::sq_small(ay4);
        near_origin = small_x && small_y && (r2 < cosl_pkg::MIN_RADIUS_SQ);
        ay17        = s_point_y[15] ? (17'd0 - {s_point_y[15], s_point_y})
                                    : {1'b0, s_point_y};
        wide_y      = ay17 > {2'b00, lat_reg};
        keep_point  = !near_origin && !wide_y && !s_point_x[15];
    end

    // velocity decision, taken from the current state at acceptance
    logic               is_disabled, non_fwd, is_stale, too_close, in_slow;
    logic [14:0]        near_cl;
    cosl_pkg::dec_t     dec_cmb;
    logic signed [16:0] gain_cmb;
    logic signed [15:0] num_cmb, den_cmb;

    logic [14:0] near_reg, run_min_reg;
    logic [15:0] data_age_reg, dis_age_reg;

    always_comb begin
        is_disabled = dis_age_reg < timeout_reg;
        non_fwd     = s_speed_request[15] || (s_speed_request == 16'sd0);
        is_stale    = data_age_reg > timeout_reg;
        too_close   = near_reg <= stop_reg;
        in_slow     = near_reg < slow_reg;
        near_cl     = (near_reg < floor_reg) ? floor_reg : near_reg;
        if (is_disabled)            dec_cmb = cosl_pkg::DEC_DISABLED;
        else if (non_fwd)           dec_cmb = cosl_pkg::DEC_NON_FWD;
        else if (is_stale)          dec_cmb = cosl_pkg::DEC_STALE;
        else if (too_close)         dec_cmb = allow_rev_reg ? cosl_pkg::DEC_REVERSE
                                                            : cosl_pkg::DEC_STOP;
        else if (in_slow)           dec_cmb = cosl_pkg::DEC_LIMITED;
        else                        dec_cmb = cosl_pkg::DEC_FREE;
        if (dec_cmb == cosl_pkg::DEC_REVERSE) begin
            gain_cmb = {rev_max_reg[15], rev_max_reg};
            num_cmb  = $signed({1'b0, stop_reg} - {1'b0, near_cl});
            den_cmb  = $signed({1'b0, stop_reg} - {1'b0, floor_reg});
        end else begin
            gain_cmb = $signed({2'b00, fwd_max_reg});
            num_cmb  = $signed({1'b0, near_reg} - {1'b0, stop_reg});
            den_cmb  = $signed({1'b0, slow_reg} - {1'b0, stop_reg});
        end
    end

    // ---------------- scan state and ages ----------------
    logic [14:0] near_next, run_min_next;
    logic [15:0] data_age_next, dis_age_next;

    always_comb begin
        near_next     = near_reg;
        run_min_next  = run_min_reg;
        data_age_next = data_age_reg;
        dis_age_next  = dis_age_reg;
        if (cmd.take) begin
            case (op)
                cosl_pkg::OP_POINT: begin
                    if (keep_point && (s_point_x[14:0] < run_min_reg)) begin
                        run_min_next = s_point_x[14:0];
                    end
                end
                cosl_pkg::OP_END_SCAN: begin
                    near_next     = run_min_reg;
                    run_min_next  = cosl_pkg::FAR_DIST;
                    data_age_next = 16'd0;
                end
                cosl_pkg::OP_VELOCITY: begin
                    // store the clamped distance when backing away
                    if (dec_cmb == cosl_pkg::DEC_REVERSE) begin
                        near_next = near_cl;
                    end
                end
                cosl_pkg::OP_DISABLE: dis_age_next = 16'd0;
                cosl_pkg::OP_ENABLE:  dis_age_next = cosl_pkg::AGE_MAX;
                cosl_pkg::OP_TICK: begin
                    if (data_age_reg != cosl_pkg::AGE_MAX) data_age_next = data_age_reg + 16'd1;
                    if (dis_age_reg != cosl_pkg::AGE_MAX)  dis_age_next  = dis_age_reg + 16'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg     <= cosl_pkg::FAR_DIST;
            run_min_reg  <= cosl_pkg::FAR_DIST;
            data_age_reg <= cosl_pkg::AGE_MAX;
            dis_age_reg  <= cosl_pkg::AGE_MAX;
        end else begin
            near_reg     <= near_next;
            run_min_reg  <= run_min_next;
            data_age_reg <= data_age_next;
            dis_age_reg  <= dis_age_next;
        end
    end

    // ---------------- velocity operands ----------------
    logic signed [15:0] want_reg, turn_reg, num_reg, den_reg;
    logic signed [16:0] gain_reg;
    cosl_pkg::dec_t     dec_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take && (op == cosl_pkg::OP_VELOCITY)) begin
            want_reg <= s_speed_request;
            turn_reg <= s_turn_request;
            dec_reg  <= dec_cmb;
            gain_reg <= gain_cmb;
            num_reg  <= num_cmb;
            den_reg  <= den_cmb;
        end
    end

    // ---------------- multiply ----------------
    logic signed [32:0] prod_full;
    logic signed [31:0] prod_reg;

    assign prod_full = $signed(33'(gain_reg)) * $signed(33'(num_reg));

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod_full[31:0];
        end
    end

    // ---------------- divide (sign and magnitude) ----------------
    logic [31:0]                  prod_mag;
    logic [15:0]                  den_mag;
    logic [30:0]                  quo_reg, quo_next;
    logic [14:0]                  rem_reg, rem_next, dvs_reg;
    logic [15:0]                  rem_sh;
    logic                         neg_reg;
    logic [cosl_pkg::DIV_CNT_W-1:0] cnt_reg;

    always_comb begin
        prod_mag = prod_reg[31] ? (32'd0 - prod_reg) : prod_reg;
        den_mag  = den_reg[15] ? (16'd0 - den_reg) : den_reg;
        rem_sh   = {rem_reg, quo_reg[30]};
        if (rem_sh >= {1'b0, dvs_reg}) begin
            rem_next = 15'(rem_sh - {1'b0, dvs_reg});
            quo_next = {quo_reg[29:0], 1'b1};
        end else begin
            rem_next = rem_sh[14:0];
            quo_next = {quo_reg[29:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            quo_reg <= prod_mag[30:0];
            rem_reg <= 15'd0;
            dvs_reg <= den_mag[14:0];
            neg_reg <= prod_reg[31] ^ den_reg[15];
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + cosl_pkg::DIV_CNT_W'(1);
        end
    end

    // ---------------- result ----------------
    logic signed [15:0] ramp_val, speed_res, turn_res;

    always_comb begin
        if (den_reg == 16'sd0) begin
            ramp_val = 16'sd0;
        end else if (neg_reg) begin
            ramp_val = (quo_reg > 31'd32768) ? -16'sd32768 : $signed(16'd0 - quo_reg[15:0]);
        end else begin
            ramp_val = (quo_reg > 31'd32767) ? 16'sd32767 : $signed(quo_reg[15:0]);
        end
        turn_res = turn_reg;
        case (dec_reg) inside
            cosl_pkg::DEC_STALE,
            cosl_pkg::DEC_STOP:    speed_res = 16'sd0;
            cosl_pkg::DEC_REVERSE: begin
                speed_res = ramp_val;
                turn_res  = 16'sd0;
            end
            cosl_pkg::DEC_LIMITED: speed_res = (want_reg < ramp_val) ? want_reg : ramp_val;
            default:               speed_res = want_reg;
        endcase
    end

    logic               m_valid_reg;
    logic signed [15:0] m_speed_reg, m_turn_reg;
    cosl_pkg::dec_t     m_dec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_speed_reg <= speed_res;
            m_turn_reg  <= turn_res;
            m_dec_reg   <= dec_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_speed_out = m_speed_reg;
    assign m_turn_out  = m_turn_reg;
    assign m_decision  = m_dec_reg;

    assign sts.op_velocity = (op == cosl_pkg::OP_VELOCITY);
    assign sts.ramp_needed = ((dec_cmb == cosl_pkg::DEC_REVERSE) ||
                              (dec_cmb == cosl_pkg::DEC_LIMITED)) && (den_cmb != 16'sd0);
    assign sts.div_last    = (cnt_reg == cosl_pkg::DIV_CNT_W'(cosl_pkg::DIV_STEPS - 1));
    assign sts.out_full    = m_valid_reg;

    `COSL_ASSERT(a_end_scan_fresh, cmd.take && op == cosl_pkg::OP_END_SCAN |=> data_age_reg == 16'd0, "end of scan left data stale")
    `COSL_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid_reg, "result valid after reset")

endmodule
`default_nettype wire

@@ hdl/corridor_obstacle_speed_limiter_unit.sv @@
// Corridor obstacle speed limiter, top level.
// Instantiates cosl_ctrl and cosl_dp; depends on cosl_pkg.
//
// Use: scan points, end-of-scan marks, enable/disable and ticks enter on the
// s_ channel (valid/ready) and are absorbed on acceptance, so a scan streams
// at one point per clock while no velocity request is in progress. A velocity
// request yields one result on the m_ channel (valid/ready); the other
// requests yield none. A request whose decision needs no ramp (disabled,
// non-forward, stale, stop, free, or a zero ramp divisor) goes straight to
// the result load; a reverse or limited ramp passes a multiply, a divider
// load, the bit-serial restoring divider and the result load. s_ready is
// low until the result is loaded.
// A waiting result sits in the output register; further non-velocity
// requests are still taken, a new velocity request is held off until the
// result has been taken on m_.
// Reset (aresetn low, synchronous) restores the register defaults, marks
// the scan data stale and the block enabled, and drops any pending result.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at
// once and are to be issued only while the block is idle.
`default_nettype none
module corridor_obstacle_speed_limiter_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_opcode,
    input  wire logic signed [15:0] s_point_x,
    input  wire logic signed [15:0] s_point_y,
    input  wire logic signed [15:0] s_speed_request,
    input  wire logic signed [15:0] s_turn_request,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_speed_out,
    output logic signed [15:0]      m_turn_out,
    output logic [2:0]              m_decision
);

    cosl_pkg::cmd_t cmd;
    cosl_pkg::sts_t sts;

    cosl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cosl_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_opcode        (s_opcode),
        .s_point_x       (s_point_x),
        .s_point_y       (s_point_y),
        .s_speed_request (s_speed_request),
        .s_turn_request  (s_turn_request),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_speed_out     (m_speed_out),
        .m_turn_out      (m_turn_out),
        .m_decision      (m_decision),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule
`default_nettype wire
